>>> rtl/core/bpd_pkg.sv
`default_nettype none

package bpd_pkg;

   // list capacity and derived widths
   localparam int CAPACITY = 256;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = 8;
   localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int REC_W    = 24;

   // stream widths
   localparam int REQ_TUSER_W = 3;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TUSER_W = 2;
   localparam int RSP_COUNT_W = 9;
   localparam int RSP_FIELD_W = RSP_COUNT_W + 3 * REC_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   // command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef logic [REC_W-1:0]  rec_type;   // {x, y, glyph}, x in the top byte
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  count_type;

   typedef enum logic [2:0] {
      OP_INS_HEAD = 3'd0,
      OP_INS_TAIL = 3'd1,
      OP_REM_HEAD = 3'd2,
      OP_REM_TAIL = 3'd3,
      OP_READ     = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_INS_HEAD,
      CMD_INS_TAIL,
      CMD_REM_HEAD,
      CMD_REM_TAIL,
      CMD_READ
   } cmd_kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      cmd_kind_type        kind;
      rec_type             rec;
      logic [IDX_W-1:0]    idx;
   } cmd_type;

   // physical slot of (head + offset), offset below CAPACITY
   function automatic addr_type slot_add(input addr_type head, input addr_type offset);
      logic [ADDR_W:0] sum;
      sum = {1'b0, head} + {1'b0, offset};
      if (sum >= (ADDR_W + 1)'(CAPACITY)) begin
         sum = sum - (ADDR_W + 1)'(CAPACITY);
      end
      return sum[ADDR_W-1:0];
   endfunction

   // physical slot one place before head
   function automatic addr_type slot_dec(input addr_type head);
      addr_type res;
      if (head == '0) begin
         res = ADDR_W'(CAPACITY - 1);
      end else begin
         res = head - ADDR_W'(1);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/bounded_position_deque_core.sv
`default_nettype none
// sequence: the back end takes a command in its execute step, then a lookup
//   step, then a deliver step on the two-read-port entry memory; it takes no new
//   command until the deliver step has loaded the response register
// reset: synchronous, clears head pointer, count, command queue and output valid;
//   the entry memory is not cleared; head and tail fields are zero while the list is empty

module bounded_position_deque_core (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bpd_pkg::REQ_TDATA_W-1:0] req_tdata,  // pos_x, pos_y, glyph, read_index
   input  logic [bpd_pkg::REQ_TUSER_W-1:0] req_tuser,  // op
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // count, head_x, head_y, head_glyph, tail_x, tail_y, tail_glyph,
   // read_x, read_y, read_glyph, zero pad
   output logic [bpd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [bpd_pkg::RSP_TUSER_W-1:0] rsp_tuser   // status
);
   import bpd_pkg::*;

   cmd_type front_cmd;   // decoded request
   cmd_type back_cmd;    // oldest queued command
   logic    back_valid;
   logic    back_ready;

   // front: decode the opcode into a command, no state of its own
   bpd_front u_front (
      .req_op   (req_tuser),
      .req_data (req_tdata),
      .cmd      (front_cmd)
   );

   // short queue lets the request side keep taking transfers while the
   // back end is busy or the response side stalls
   bpd_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_cmd   (back_cmd)
   );

   // back: circular buffer update, entry lookups and the output register
   bpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (back_valid),
      .q_ready    (back_ready),
      .q_cmd      (back_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

>>> rtl/core/bpd_front.sv
`default_nettype none

module bpd_front (
   input  logic [bpd_pkg::REQ_TUSER_W-1:0] req_op,     // op
   input  logic [bpd_pkg::REQ_TDATA_W-1:0] req_data,   // pos_x, pos_y, glyph, read_index
   output bpd_pkg::cmd_type                cmd
);
   import bpd_pkg::*;

   // classify the opcode, unused codes become no-ops
   always_comb begin
      cmd.rec = {req_data[7:0], req_data[15:8], req_data[23:16]};
      cmd.idx = req_data[31:24];
      case (req_op)
         OP_INS_HEAD: cmd.kind = CMD_INS_HEAD;
         OP_INS_TAIL: cmd.kind = CMD_INS_TAIL;
         OP_REM_HEAD: cmd.kind = CMD_REM_HEAD;
         OP_REM_TAIL: cmd.kind = CMD_REM_TAIL;
         OP_READ:     cmd.kind = CMD_READ;
         default:     cmd.kind = CMD_NOP;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/bpd_cmd_queue.sv
`default_nettype none

module bpd_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  bpd_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output bpd_pkg::cmd_type out_cmd
);
   import bpd_pkg::*;

   cmd_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;
   logic                push, pop;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
      logic [QPTR_W-1:0] res;
      if (ptr == QPTR_W'(QDEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + QPTR_W'(1);
      end
      return res;
   endfunction

   assign in_ready  = (fill_ff != QCNT_W'(QDEPTH));
   assign out_valid = (fill_ff != '0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/bpd_back.sv
`default_nettype none

module bpd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   output logic                            q_ready,
   input  bpd_pkg::cmd_type                q_cmd,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bpd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [bpd_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import bpd_pkg::*;

   typedef enum logic [2:0] {
      S_EXEC = 3'b001,
      S_LOOK = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   addr_type                 head_ff, head_in;
   count_type                count_ff, count_in;
   status_type               status_ff, status_in;
   logic                     rd_ok_ff, rd_ok_in;
   rec_type                  read_rec_ff, read_rec_in;
   rec_type                  rd_a_ff, rd_b_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_TUSER_W-1:0]   rsp_tuser_ff, rsp_tuser_in;

   rec_type                  mem [CAPACITY];
   logic                     wr_en, rd_a_en, rd_b_en;
   addr_type                 wr_addr, rd_a_addr, rd_b_addr;
   logic                     is_full, is_empty;
   logic [CMP_W-1:0]         idx_wide, cnt_wide;
   rec_type                  head_rec, tail_rec;

   // record fields lowest first: x, y, glyph
   function automatic logic [REC_W-1:0] rec_lsb_first(input rec_type rec);
      return {rec[7:0], rec[15:8], rec[23:16]};
   endfunction

   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign idx_wide = CMP_W'(q_cmd.idx);
   assign cnt_wide = CMP_W'(count_ff);
   assign head_rec = is_empty ? '0 : rd_a_ff;
   assign tail_rec = is_empty ? '0 : rd_b_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      rd_ok_in     = rd_ok_ff;
      read_rec_in  = read_rec_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_tdata_in = rsp_tdata_ff;
      rsp_tuser_in = rsp_tuser_ff;
      q_ready      = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = head_ff;
      rd_a_en      = 1'b0;
      rd_a_addr    = head_ff;
      rd_b_en      = 1'b0;
      rd_b_addr    = head_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_EXEC: begin
            q_ready = 1'b1;
            if (q_valid) begin
               status_in = ST_OK;
               rd_ok_in  = 1'b0;
               state_in  = S_LOOK;
               case (q_cmd.kind)
                  CMD_INS_HEAD: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = slot_dec(head_ff);
                        head_in  = wr_addr;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_INS_TAIL: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = slot_add(head_ff, ADDR_W'(count_ff));
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_REM_HEAD: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        head_in  = slot_add(head_ff, ADDR_W'(1));
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_REM_TAIL: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_READ: begin
                     if (idx_wide >= cnt_wide) begin
                        status_in = ST_RANGE;
                     end else begin
                        rd_b_en   = 1'b1;
                        rd_b_addr = slot_add(head_ff, ADDR_W'(q_cmd.idx));
                        rd_ok_in  = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LOOK: begin
            // pick up the indexed entry, then fetch head and tail
            read_rec_in = rd_ok_ff ? rd_b_ff : '0;
            rd_a_en     = 1'b1;
            rd_b_en     = 1'b1;
            rd_b_addr   = slot_add(head_ff, ADDR_W'(count_ff - CNT_W'(1)));
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_tuser_in = status_ff;
               rsp_tdata_in = {{RSP_PAD_W{1'b0}},
                               rec_lsb_first(read_rec_ff),
                               rec_lsb_first(tail_rec),
                               rec_lsb_first(head_rec),
                               RSP_COUNT_W'(count_ff)};
               state_in     = S_EXEC;
            end
         end
         default: begin
            state_in = S_EXEC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_EXEC;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      rd_ok_ff     <= rd_ok_in;
      read_rec_ff  <= read_rec_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   // entry memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= q_cmd.rec;
      end
      if (rd_a_en) begin
         rd_a_ff <= mem[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= mem[rd_b_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOK && status_ff == ST_FULL) |-> is_full)
      else $error("full status with room left");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOK && status_ff == ST_EMPTY) |-> is_empty)
      else $error("empty status with entries present");

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside of deliver step");

endmodule

`default_nettype wire
